[design/allpass_halfband_decimator_assert.svh]
// Assertion helpers for the halfband decimator.
`ifndef ALLPASS_HALFBAND_DECIMATOR_ASSERT_SVH
`define ALLPASS_HALFBAND_DECIMATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define AHD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define AHD_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define AHD_ASSERT(lbl, clk, rst_n, prop, msg)

`define AHD_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[design/ahd_pkg.sv]
`default_nettype none

package ahd_pkg;

    localparam int AHD_MAX_SECTIONS = 6;
    localparam int AHD_SAMPLE_BITS  = 24;
    localparam int COEF_BITS        = 18;
    localparam int COEF_FRAC        = 18;
    localparam int GENTLE_SECTIONS  = 2;
    localparam int SHARP_SECTIONS   = 6;
    localparam int LANES            = 4;
    localparam int LANE_BITS        = 2;
    localparam int SECT_BITS        = 3;

    localparam logic [LANE_BITS-1:0] LANE_LEFT_A  = 2'd0;
    localparam logic [LANE_BITS-1:0] LANE_RIGHT_A = 2'd1;
    localparam logic [LANE_BITS-1:0] LANE_LEFT_B  = 2'd2;
    localparam logic [LANE_BITS-1:0] LANE_RIGHT_B = 2'd3;

    typedef struct packed {
        logic                 valid;
        logic [LANE_BITS-1:0] lane;
    } tag_t;

    // Q0.18 allpass coefficients; branch 0 feeds even samples, branch 1 odd.
    function automatic logic [COEF_BITS-1:0] coef(
        input logic                 sharp,
        input logic                 branch,
        input logic [SECT_BITS-1:0] sect
    );
        logic [COEF_BITS-1:0] c;
        c = '0;
        case ({sharp, branch, sect})
            {1'b0, 1'b0, 3'd0}: c = 18'd43813;
            {1'b0, 1'b0, 3'd1}: c = 18'd194545;
            {1'b0, 1'b1, 3'd0}: c = 18'd10841;
            {1'b0, 1'b1, 3'd1}: c = 18'd101684;
            {1'b1, 1'b0, 3'd0}: c = 18'd24385;
            {1'b1, 1'b0, 3'd1}: c = 18'd81872;
            {1'b1, 1'b0, 3'd2}: c = 18'd143754;
            {1'b1, 1'b0, 3'd3}: c = 18'd193252;
            {1'b1, 1'b0, 3'd4}: c = 18'd228651;
            {1'b1, 1'b0, 3'd5}: c = 18'd255721;
            {1'b1, 1'b1, 3'd0}: c = 18'd6393;
            {1'b1, 1'b1, 3'd1}: c = 18'd50864;
            {1'b1, 1'b1, 3'd2}: c = 18'd113733;
            {1'b1, 1'b1, 3'd3}: c = 18'd170426;
            {1'b1, 1'b1, 3'd4}: c = 18'd212446;
            {1'b1, 1'b1, 3'd5}: c = 18'd242740;
            default:            c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[design/ahd_cell.sv]
`default_nettype none

module ahd_cell
    import ahd_pkg::*;
#(
    parameter int SAMPLE_BITS = AHD_SAMPLE_BITS,
    parameter int INDEX       = 0
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sharp,
    input  wire tag_t                          tag_in,
    input  wire logic signed [SAMPLE_BITS-1:0] x_in,
    output tag_t                               tag_out,
    output logic signed [SAMPLE_BITS-1:0]      y_out
);

    localparam int W  = SAMPLE_BITS;
    localparam int PW = W + COEF_BITS + 2;
    localparam logic signed [PW-1:0] RND = PW'(2 ** (COEF_FRAC - 1));

    // per-lane section state
    logic signed [W-1:0] prev_in_reg  [LANES];
    logic signed [W-1:0] prev_out_reg [LANES];

    logic                 en;
    logic [COEF_BITS-1:0] c;
    logic signed [W:0]    delta;
    logic signed [PW-1:0] prod;

    tag_t                 s1_tag_reg;
    logic                 s1_en_reg;
    logic signed [PW-1:0] s1_prod_reg;
    logic signed [W-1:0]  s1_pin_reg;

    logic signed [PW-1:0] rnd;
    logic signed [W+1:0]  shifted;
    logic signed [W+2:0]  sum;
    logic signed [W-1:0]  y_next;

    tag_t                 tag_out_reg;
    logic signed [W-1:0]  y_out_reg;

    // sections past the gentle count sit out in gentle mode and keep their state
    assign en    = tag_in.valid && (sharp || (INDEX < GENTLE_SECTIONS));
    assign c     = coef(sharp, tag_in.lane[1], SECT_BITS'(INDEX));
    assign delta = {x_in[W-1], x_in}
                 - {prev_out_reg[tag_in.lane][W-1], prev_out_reg[tag_in.lane]};
    assign prod  = PW'($signed({1'b0, c})) * PW'(delta);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s1_en_reg  <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                prev_in_reg[i] <= '0;
            end
        end
        else
        begin
            // drop the word's valid where the section sits out, so no word
            // lingers down the chain after the item is done
            s1_tag_reg <= {en, tag_in.lane};
            s1_en_reg  <= en;
            if (en)
            begin
                prev_in_reg[tag_in.lane] <= x_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg <= prod;
        s1_pin_reg  <= prev_in_reg[tag_in.lane];
    end

    // round to the sample grid, add the delayed input, saturate
    assign rnd     = s1_prod_reg + RND;
    assign shifted = rnd[PW-1:COEF_FRAC];
    assign sum     = {shifted[W+1], shifted} + {{3{s1_pin_reg[W-1]}}, s1_pin_reg};

    always_comb
    begin
        if (sum[W+2:W-1] == '0 || sum[W+2:W-1] == '1)
        begin
            y_next = sum[W-1:0];
        end
        else if (sum[W+2])
        begin
            y_next = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            y_next = {1'b0, {(W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_out_reg <= '0;
            for (int i = 0; i < LANES; i++)
            begin
                prev_out_reg[i] <= '0;
            end
        end
        else
        begin
            tag_out_reg <= s1_tag_reg;
            if (s1_en_reg)
            begin
                prev_out_reg[s1_tag_reg.lane] <= y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        y_out_reg <= y_next;
    end

    assign tag_out = tag_out_reg;
    assign y_out   = y_out_reg;

endmodule

`default_nettype wire

[design/allpass_halfband_decimator.sv]
// An item runs through N sections, N = 2 (gentle) or MAX_SECTIONS (sharp); no new item
// is taken until the current one has been moved to the output register (in_stall outside idle).
// The four lanes enter the section chain one per cycle; each section is a two-stage cell,
// so the latency grows with the chain depth. A finished word waits in the output register
// while the next item runs. Reset clears all section state, the mode and the handshakes.
`default_nettype none

module allpass_halfband_decimator
    import ahd_pkg::*;
#(
    parameter int MAX_SECTIONS = AHD_MAX_SECTIONS,
    parameter int SAMPLE_BITS  = AHD_SAMPLE_BITS
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] left_even,
    input  wire logic signed [SAMPLE_BITS-1:0] right_even,
    input  wire logic signed [SAMPLE_BITS-1:0] left_odd,
    input  wire logic signed [SAMPLE_BITS-1:0] right_odd,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0]      left_out,
    output logic signed [SAMPLE_BITS-1:0]      right_out,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          sharp_mode
);

`include "allpass_halfband_decimator_assert.svh"

    localparam int W = SAMPLE_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FEED = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [LANE_BITS-1:0] lane_cnt_reg, lane_cnt_next;
    logic                 sharp_mode_reg;
    logic signed [W-1:0]  sample_reg [LANES];
    logic signed [W-1:0]  res_reg    [LANES];
    logic                 out_valid_reg;
    logic signed [W-1:0]  out_left_reg, out_right_reg;

    tag_t                 chain_tag  [MAX_SECTIONS+1];
    logic signed [W-1:0]  chain_data [MAX_SECTIONS+1];
    tag_t                 tap_tag;
    logic signed [W-1:0]  tap_data;

    logic                 in_take;
    logic                 out_take;
    logic                 out_load;
    logic signed [W:0]    left_sum, right_sum;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sharp_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sharp_mode_reg <= sharp_mode;
        end
    end

    // feed one lane a cycle into the head of the chain
    assign chain_tag[0].valid = (state_reg == ST_FEED);
    assign chain_tag[0].lane  = lane_cnt_reg;
    assign chain_data[0]      = sample_reg[lane_cnt_reg];

    for (genvar s = 0; s < MAX_SECTIONS; s++)
    begin : g_cell
        ahd_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .INDEX       (s)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .sharp   (sharp_mode_reg),
            .tag_in  (chain_tag[s]),
            .x_in    (chain_data[s]),
            .tag_out (chain_tag[s+1]),
            .y_out   (chain_data[s+1])
        );
    end

    assign tap_tag  = sharp_mode_reg ? chain_tag[MAX_SECTIONS]  : chain_tag[GENTLE_SECTIONS];
    assign tap_data = sharp_mode_reg ? chain_data[MAX_SECTIONS] : chain_data[GENTLE_SECTIONS];

    always_comb
    begin
        state_next    = state_reg;
        lane_cnt_next = lane_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next    = ST_FEED;
                    lane_cnt_next = LANE_LEFT_A;
                end
            end
            ST_FEED:
            begin
                lane_cnt_next = lane_cnt_reg + 1'b1;
                if (lane_cnt_reg == LANE_RIGHT_B)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (tap_tag.valid && tap_tag.lane == LANE_RIGHT_B)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lane_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            lane_cnt_reg <= lane_cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg[LANE_LEFT_A]  <= left_even;
            sample_reg[LANE_RIGHT_A] <= right_even;
            sample_reg[LANE_LEFT_B]  <= left_odd;
            sample_reg[LANE_RIGHT_B] <= right_odd;
        end
        if (state_reg == ST_RUN && tap_tag.valid)
        begin
            res_reg[tap_tag.lane] <= tap_data;
        end
        if (out_load)
        begin
            out_left_reg  <= left_sum[W:1];
            out_right_reg <= right_sum[W:1];
        end
    end

    // floor((a + b + 1) / 2) of two in-range samples always lands in range
    assign left_sum  = {res_reg[LANE_LEFT_A][W-1], res_reg[LANE_LEFT_A]}
                     + {res_reg[LANE_LEFT_B][W-1], res_reg[LANE_LEFT_B]} + (W+1)'(1);
    assign right_sum = {res_reg[LANE_RIGHT_A][W-1], res_reg[LANE_RIGHT_A]}
                     + {res_reg[LANE_RIGHT_B][W-1], res_reg[LANE_RIGHT_B]} + (W+1)'(1);

    assign out_valid = out_valid_reg;
    assign left_out  = out_left_reg;
    assign right_out = out_right_reg;

    `AHD_ASSERT(a_tap_only_in_run, clk, rst_n, tap_tag.valid |-> state_reg == ST_RUN, "chain word outside run phase")
    `AHD_ASSERT(a_last_lane_done, clk, rst_n, (tap_tag.valid && tap_tag.lane == LANE_RIGHT_B) |=> state_reg == ST_DONE, "last lane did not finish item")
    `AHD_ASSERT(a_done_loads_out, clk, rst_n, (state_reg == ST_DONE && !(out_valid_reg && out_stall)) |=> (out_valid_reg && state_reg == ST_IDLE), "finished item not moved to output")
    `AHD_NEVER(a_no_head_while_idle, clk, rst_n, chain_tag[0].valid && (state_reg == ST_IDLE || state_reg == ST_DONE), "chain fed outside feed phase")

endmodule

`default_nettype wire
